@@ rtl/tcr_pkg.sv @@
// Shared types, codes and the 8x16 glyph table for the text cell renderer.
// No dependencies; every other file refers to this package by scoped names.
package tcr_pkg;

   typedef struct packed {
      logic       start_req;
      logic [3:0] start_col;
      logic [2:0] start_row;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [9:0] byte_addr;
      logic [7:0] byte_data;
      logic       last;
   } rsp_type;

   // One glyph: eight pixel columns, low byte on the cursor page, high byte below
   typedef logic [0:7][15:0] glyph_type;

   typedef struct packed {
      logic [9:0] base_addr;
      glyph_type  glyph;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] FIRST_CODE   = 8'd32;
   localparam logic [7:0] LAST_CODE    = 8'd159;
   localparam logic [3:0] ROW_MAX      = 4'd15;
   localparam logic [3:0] LAST_BEAT    = 4'd15;
   localparam int         STORED_CODES = 100;

   // Glyphs for codes 32 to 131; codes 132 to 159 read as blank
   localparam glyph_type FONT_ROM [STORED_CODES] = '{
      '{16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000},
      '{16'h0000,16'h0000,16'h0000,16'h33fc,16'h33fc,16'h0000,16'h0000,16'h0000},
      '{16'h0000,16'h00fc,16'h00fc,16'h0000,16'h0000,16'h00fc,16'h00fc,16'h0000},
      '{16'h0330,16'h0ffc,16'h0ffc,16'h0330,16'h0330,16'h0ffc,16'h0ffc,16'h0330},
      '{16'h0000,16'h0c78,16'h0cfc,16'h3ccf,16'h3ccf,16'h0fcc,16'h078c,16'h0000},
      '{16'h0000,16'h0c1c,16'h0f1c,16'h03c0,16'h00f0,16'h0e3c,16'h0e0c,16'h0000},
      '{16'h1f00,16'h3fce,16'h30ff,16'h33f3,16'h1f3f,16'h3f0e,16'h3300,16'h0000},
      '{16'h0000,16'h0000,16'h0000,16'h00fc,16'h00fc,16'h0000,16'h0000,16'h0000},
      '{16'h0000,16'h0000,16'h0000,16'h0ff0,16'h1ff8,16'h381c,16'h2004,16'h0000},
      '{16'h0000,16'h2004,16'h381c,16'h1ff8,16'h0ff0,16'h0000,16'h0000,16'h0000},
      '{16'h00c0,16'h0ccc,16'h0ffc,16'h03f0,16'h03f0,16'h0ffc,16'h0ccc,16'h00c0},
      '{16'h0000,16'h00c0,16'h00c0,16'h07f8,16'h07f8,16'h00c0,16'h00c0,16'h0000},
      '{16'h0000,16'h0000,16'hc000,16'h7c00,16'h3c00,16'h0000,16'h0000,16'h0000},
      '{16'h0000,16'h00c0,16'h00c0,16'h00c0,16'h00c0,16'h00c0,16'h00c0,16'h0000},
      '{16'h0000,16'h0000,16'h0000,16'h3c00,16'h3c00,16'h0000,16'h0000,16'h0000},
      '{16'h0000,16'h3800,16'h3e00,16'h0780,16'h01e0,16'h007c,16'h001c,16'h0000},
      '{16'h0000,16'h1ff8,16'h3ffc,16'h310c,16'h308c,16'h3ffc,16'h1ff8,16'h0000},
      '{16'h0000,16'h3000,16'h3030,16'h3ffc,16'h3ffc,16'h3000,16'h3000,16'h0000},
      '{16'h0000,16'h3038,16'h3c3c,16'h3f0c,16'h33cc,16'h30fc,16'h3038,16'h0000},
      '{16'h0000,16'h1c0c,16'h3c0c,16'h30cc,16'h33fc,16'h3f3c,16'h1c0c,16'h0000},
      '{16'h0000,16'h0f00,16'h0fc0,16'h0cf0,16'h3ffc,16'h3ffc,16'h0c00,16'h0000},
      '{16'h0000,16'h18fc,16'h38fc,16'h30cc,16'h30cc,16'h3fcc,16'h1f8c,16'h0000},
      '{16'h0000,16'h1ff0,16'h3ff8,16'h319c,16'h318c,16'h3f8c,16'h1f00,16'h0000},
      '{16'h0000,16'h000c,16'h3c0c,16'h3f0c,16'h03cc,16'h00fc,16'h003c,16'h0000},
      '{16'h0000,16'h1f38,16'h3ffc,16'h30cc,16'h30cc,16'h3ffc,16'h1f38,16'h0000},
      '{16'h0000,16'h0078,16'h30fc,16'h30cc,16'h38cc,16'h1ffc,16'h0ff8,16'h0000},
      '{16'h0000,16'h0000,16'h0000,16'h3cf0,16'h3cf0,16'h0000,16'h0000,16'h0000},
      '{16'h0000,16'h0000,16'hc000,16'h7cf0,16'h3cf0,16'h0000,16'h0000,16'h0000},
      '{16'h0080,16'h01c0,16'h03e0,16'h0770,16'h0e38,16'h0c18,16'h0808,16'h0000},
      '{16'h0000,16'h0330,16'h0330,16'h0330,16'h0330,16'h0330,16'h0330,16'h0000},
      '{16'h0808,16'h0c18,16'h0e38,16'h0770,16'h03e0,16'h01c0,16'h0080,16'h0000},
      '{16'h0000,16'h0038,16'h003c,16'h370c,16'h37cc,16'h00fc,16'h0038,16'h0000},
      '{16'h0ff0,16'h1ff8,16'h381c,16'h33cc,16'h324c,16'h3398,16'h19f0,16'h0000},
      '{16'h0000,16'h3ff0,16'h3ff8,16'h031c,16'h031c,16'h3ff8,16'h3ff0,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h30cc,16'h30cc,16'h3ffc,16'h1f78,16'h0000},
      '{16'h0000,16'h1ff8,16'h3ffc,16'h300c,16'h300c,16'h3c3c,16'h1c38,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h300c,16'h381c,16'h1ff8,16'h0ff0,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h30cc,16'h30cc,16'h30cc,16'h300c,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h00cc,16'h00cc,16'h00cc,16'h000c,16'h0000},
      '{16'h0000,16'h1ff8,16'h3ffc,16'h300c,16'h30cc,16'h3fcc,16'h1fcc,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h00c0,16'h00c0,16'h3ffc,16'h3ffc,16'h0000},
      '{16'h0000,16'h300c,16'h300c,16'h3ffc,16'h3ffc,16'h300c,16'h300c,16'h0000},
      '{16'h0000,16'h1c00,16'h3c00,16'h3000,16'h3000,16'h3ffc,16'h1ffc,16'h0000},
      '{16'h3ffc,16'h3ffc,16'h00c0,16'h03f0,16'h0f3c,16'h3c0c,16'h3000,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h3000,16'h3000,16'h3000,16'h3000,16'h0000},
      '{16'h3ffc,16'h3ffc,16'h0070,16'h01c0,16'h0070,16'h3ffc,16'h3ffc,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h01e0,16'h0780,16'h3ffc,16'h3ffc,16'h0000},
      '{16'h0000,16'h1ff8,16'h3ffc,16'h300c,16'h300c,16'h3ffc,16'h1ff8,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h030c,16'h030c,16'h03fc,16'h01f8,16'h0000},
      '{16'h0000,16'h1ff8,16'h3ffc,16'h300c,16'h180c,16'h37fc,16'h2ff8,16'h0000},
      '{16'h3ffc,16'h3ffc,16'h018c,16'h038c,16'h0ffc,16'h3cf8,16'h3000,16'h0000},
      '{16'h0000,16'h3078,16'h30fc,16'h31cc,16'h338c,16'h3f0c,16'h1e0c,16'h0000},
      '{16'h0000,16'h000c,16'h000c,16'h3ffc,16'h3ffc,16'h000c,16'h000c,16'h0000},
      '{16'h0000,16'h1ffc,16'h3ffc,16'h3000,16'h3000,16'h3ffc,16'h1ffc,16'h0000},
      '{16'h0000,16'h03fc,16'h0ffc,16'h3c00,16'h3c00,16'h0ffc,16'h03fc,16'h0000},
      '{16'h3ffc,16'h1ffc,16'h0e00,16'h0780,16'h0e00,16'h1ffc,16'h3ffc,16'h0000},
      '{16'h0000,16'h381c,16'h3e7c,16'h07e0,16'h07e0,16'h3e7c,16'h381c,16'h0000},
      '{16'h0000,16'h003c,16'h00fc,16'h3fc0,16'h3fc0,16'h00fc,16'h003c,16'h0000},
      '{16'h0000,16'h3c0c,16'h3f0c,16'h33cc,16'h30fc,16'h303c,16'h300c,16'h0000},
      '{16'h0000,16'h0000,16'h0000,16'h3ffc,16'h3ffc,16'h300c,16'h300c,16'h0000},
      '{16'h0000,16'h001c,16'h007c,16'h01e0,16'h0780,16'h3e00,16'h3800,16'h0000},
      '{16'h0000,16'h300c,16'h300c,16'h3ffc,16'h3ffc,16'h0000,16'h0000,16'h0000},
      '{16'h0180,16'h01e0,16'h0078,16'h001e,16'h0078,16'h01e0,16'h0180,16'h0000},
      '{16'h3000,16'h3000,16'h3000,16'h3000,16'h3000,16'h3000,16'h3000,16'h0000},
      '{16'h0000,16'h0007,16'h000e,16'h001c,16'h0038,16'h0070,16'h0000,16'h0000},
      '{16'h0000,16'h1e00,16'h3f60,16'h3360,16'h3360,16'h3fe0,16'h3fc0,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h3060,16'h3060,16'h3fe0,16'h1fc0,16'h0000},
      '{16'h0000,16'h1fc0,16'h3fe0,16'h3060,16'h3060,16'h3060,16'h3000,16'h0000},
      '{16'h0000,16'h1fc0,16'h3fe0,16'h3060,16'h3060,16'h3ffc,16'h3ffc,16'h0000},
      '{16'h0000,16'h1fc0,16'h3fe0,16'h3260,16'h3260,16'h33e0,16'h33c0,16'h0000},
      '{16'h0000,16'h00c0,16'h00c0,16'h3ff8,16'h3ffc,16'h00cc,16'h00cc,16'h0000},
      '{16'h0000,16'hcfc0,16'hdfe0,16'hd860,16'hd860,16'hffe0,16'h7fe0,16'h0000},
      '{16'h0000,16'h3ffc,16'h3ffc,16'h0060,16'h0060,16'h3fe0,16'h3fc0,16'h0000},
      '{16'h0000,16'h0000,16'h3060,16'h3fec,16'h3fec,16'h3000,16'h0000,16'h0000},
      '{16'h0000,16'hc000,16'hc000,16'hc000,16'hffec,16'h7fec,16'h0000,16'h0000},
      '{16'h3ffc,16'h3ffc,16'h0380,16'h07c0,16'h1ee0,16'h3860,16'h3000,16'h0000},
      '{16'h0000,16'h0000,16'h300c,16'h3ffc,16'h3ffc,16'h3000,16'h0000,16'h0000},
      '{16'h3fc0,16'h3fe0,16'h00e0,16'h07c0,16'h00e0,16'h3fe0,16'h3fc0,16'h0000},
      '{16'h0000,16'h3fc0,16'h3fe0,16'h0060,16'h0060,16'h3fe0,16'h3fc0,16'h0000},
      '{16'h0000,16'h1fc0,16'h3fe0,16'h3060,16'h3060,16'h3fe0,16'h1fc0,16'h0000},
      '{16'h0000,16'hffe0,16'hffe0,16'h3060,16'h3060,16'h3fe0,16'h1fc0,16'h0000},
      '{16'h0000,16'h1fc0,16'h3fe0,16'h3060,16'h3060,16'hffe0,16'hffe0,16'h0000},
      '{16'h0000,16'h3fe0,16'h3fe0,16'h0060,16'h0060,16'h00e0,16'h00c0,16'h0000},
      '{16'h0000,16'h31c0,16'h33e0,16'h3360,16'h3660,16'h3e60,16'h1c60,16'h0000},
      '{16'h0000,16'h0060,16'h0060,16'h1ff8,16'h3ff8,16'h3060,16'h3060,16'h0000},
      '{16'h0000,16'h1fe0,16'h3fe0,16'h3000,16'h3000,16'h3fe0,16'h3fe0,16'h0000},
      '{16'h0000,16'h03e0,16'h0fe0,16'h3c00,16'h3c00,16'h0fe0,16'h03e0,16'h0000},
      '{16'h3fe0,16'h1fe0,16'h0e00,16'h0780,16'h0e00,16'h1fe0,16'h3fe0,16'h0000},
      '{16'h0000,16'h3060,16'h3de0,16'h0f80,16'h0f80,16'h3de0,16'h3060,16'h0000},
      '{16'h0000,16'hcfe0,16'hdfe0,16'hd800,16'hd800,16'hffe0,16'h7fe0,16'h0000},
      '{16'h0000,16'h3060,16'h3c60,16'h3f60,16'h33e0,16'h30e0,16'h3060,16'h0000},
      '{16'h0180,16'h0180,16'h03c0,16'h3ffc,16'h7e7e,16'h4002,16'h4002,16'h0000},
      '{16'h0000,16'h0000,16'h0000,16'h7ffe,16'h7ffe,16'h0000,16'h0000,16'h0000},
      '{16'h4002,16'h4002,16'h7e7e,16'h3ffc,16'h03c0,16'h0180,16'h0180,16'h0000},
      '{16'h01c0,16'h0060,16'h00e0,16'h01c0,16'h0180,16'h0180,16'h00e0,16'h0000},
      '{16'h1800,16'h1e00,16'h1380,16'h10e0,16'h10e0,16'h1380,16'h1e00,16'h1800},
      '{16'h0000,16'h0030,16'h0078,16'h00f8,16'h01f0,16'h00f8,16'h0078,16'h0030},
      '{16'h0000,16'h0008,16'h0014,16'h0008,16'h00e0,16'h0110,16'h0110,16'h00a0},
      '{16'h0000,16'h1c00,16'h3f00,16'h3fcc,16'h3f00,16'h1c00,16'h0000,16'h0000},
      '{16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000}
   };

endpackage

@@ rtl/tcr_front.sv @@
// Front end: accepts characters, keeps the text cursor and classifies each item.
// Drawn cells go to the job queue with their base address and glyph. Uses tcr_pkg.
module tcr_front #(
   parameter int CELLS_PER_ROW = 16,
   parameter int PAGES         = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcr_pkg::req_type      req_data,
   input  tcr_pkg::q_status_type q_stat,
   output tcr_pkg::push_type     push
);

   localparam int COL_W = (CELLS_PER_ROW > 16) ? $clog2(CELLS_PER_ROW) : 4;

   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [COL_W:0]   col_inc;
   logic [3:0]       row_ff, row_in, row_cur, row_adv;
   logic [4:0]       row_sum;
   logic [7:0]       glyph_idx;
   logic             accept, in_rom, on_screen, newline;

   always_comb begin
      accept    = req_valid && !q_stat.full;
      col_cur   = req_data.start_req ? COL_W'(req_data.start_col) : col_ff;
      row_cur   = req_data.start_req ? {1'b0, req_data.start_row} : row_ff;
      newline   = (req_data.char_code == tcr_pkg::NEWLINE_CODE);

      // two pages down, saturating at the bottom row code
      row_sum   = {1'b0, row_cur} + 5'd2;
      row_adv   = (row_sum > {1'b0, tcr_pkg::ROW_MAX}) ? tcr_pkg::ROW_MAX : row_sum[3:0];
      col_inc   = {1'b0, col_cur} + {{COL_W{1'b0}}, 1'b1};

      in_rom    = (req_data.char_code >= tcr_pkg::FIRST_CODE) &&
                  (req_data.char_code <= tcr_pkg::LAST_CODE);
      on_screen = ({1'b0, col_cur} < (COL_W+1)'(CELLS_PER_ROW)) &&
                  (({1'b0, row_cur} + 5'd1) < 5'(PAGES));
      glyph_idx = req_data.char_code - tcr_pkg::FIRST_CODE;

      push.valid          = accept && in_rom && on_screen;
      push.job.base_addr  = {row_cur[2:0], 7'b0} + 10'({col_cur, 3'b000});
      push.job.glyph      = (glyph_idx < 8'(tcr_pkg::STORED_CODES)) ?
                            tcr_pkg::FONT_ROM[glyph_idx[6:0]] : '0;

      if (newline) begin
         col_in = '0;
         row_in = row_adv;
      end else if (col_inc >= (COL_W+1)'(CELLS_PER_ROW)) begin
         col_in = '0;
         row_in = row_adv;
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = row_cur;
      end
   end

   assign req_stall = q_stat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ rtl/tcr_queue.sv @@
// Two-entry job queue between the front end and the write sequencer.
// Uses tcr_pkg for the job and status types.
module tcr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  tcr_pkg::push_type     push,
   input  logic                  pop,
   output tcr_pkg::q_status_type q_stat,
   output tcr_pkg::job_type      head
);

   tcr_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      q_stat.full  = (count_ff == 2'd2);
      q_stat.empty = (count_ff == 2'd0);
      do_push      = push.valid && !q_stat.full;
      do_pop       = pop && !q_stat.empty;
      count_in     = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      head         = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push.job;
   end

endmodule

@@ rtl/tcr_back.sv @@
// Write sequencer: turns one queued glyph job into sixteen framebuffer byte writes.
// Holds the result in an output register. Uses tcr_pkg.
module tcr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tcr_pkg::q_status_type q_stat,
   input  tcr_pkg::job_type      head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tcr_pkg::rsp_type      rsp_data
);

   tcr_pkg::job_type job_ff;
   tcr_pkg::rsp_type rsp_ff, rsp_in;
   logic             active_ff, rsp_valid_ff;
   logic [3:0]       beat_ff;
   logic [2:0]       pix_col;
   logic             high_half, out_adv, beat_done;

   always_comb begin
      out_adv   = !rsp_valid_ff || !rsp_stall;
      beat_done = active_ff && out_adv && (beat_ff == tcr_pkg::LAST_BEAT);
      pop       = !q_stat.empty && (!active_ff || beat_done);

      // even beats: low byte on the cursor page; odd beats: high byte a page below
      pix_col   = beat_ff[3:1];
      high_half = beat_ff[0];
      rsp_in.byte_addr = job_ff.base_addr + {2'b00, high_half, 4'b0000, pix_col};
      rsp_in.byte_data = high_half ? job_ff.glyph[pix_col][15:8] :
                                     job_ff.glyph[pix_col][7:0];
      rsp_in.last      = (beat_ff == tcr_pkg::LAST_BEAT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_adv) rsp_valid_ff <= active_ff;
         if (pop) begin
            active_ff <= 1'b1;
            beat_ff   <= '0;
         end else if (active_ff && out_adv) begin
            beat_ff <= beat_ff + 4'd1;
            if (beat_done) active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) job_ff <= head;
      if (out_adv && active_ff) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/text_cell_renderer_8x16_unit.sv @@
// Top level of the 8x16 text cell renderer: front end, job queue, write sequencer.
// Depends on tcr_pkg, tcr_front, tcr_queue and tcr_back.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   tcr_pkg::req_type (start, column, row, code)
//   rsp_     out        rsp_valid/rsp_stall   tcr_pkg::rsp_type (address, data, last)
//
// A drawn character yields sixteen byte writes, one per cycle unless the output stalls;
// the write sequencer loads the next job as the last write of a burst enters its output register.
// Newlines, off-screen cells and codes outside the glyph table push no job to the queue.
// The first write passes the queue entry, the job register and the output register.
// Reset is synchronous and clears the cursor to column 0, row 0, and empties the queue.
// A stalled output holds its write; the front end takes items until the queue fills.
module text_cell_renderer_8x16_unit #(
   parameter int CELLS_PER_ROW = 16,
   parameter int PAGES         = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcr_pkg::rsp_type rsp_data
);

   tcr_pkg::push_type     push;
   tcr_pkg::q_status_type q_stat;
   tcr_pkg::job_type      head;
   logic                  pop;

   // Track the cursor, look up the glyph and hand drawn cells to the queue
   tcr_front #(
      .CELLS_PER_ROW (CELLS_PER_ROW),
      .PAGES         (PAGES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push)
   );

   // Decouple classification from the sixteen-beat write burst
   tcr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .q_stat (q_stat),
      .head   (head)
   );

   // Emit low/high byte pairs for the eight pixel columns
   tcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && q_stat.full))
      else $error("job pushed into full queue");

   // The sequencer never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_stat.empty))
      else $error("job popped from empty queue");

   // A burst runs without gaps: a taken write that is not last is followed by another
   a_burst_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last) |=> rsp_valid)
      else $error("gap inside a character's write burst");

   // A stalled write stays offered and unchanged until it is taken
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled write changed or dropped");

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for text_cell_renderer_8x16_unit: a scripted opening, then random
// text in bursts, every byte write compared against a cursor and glyph predictor.
// Depends on tcr_pkg for the item and write payload types only.
`timescale 1ns / 1ps

module tb_top;

   localparam int CELLS_PER_ROW = 16;
   localparam int PAGES         = 8;
   localparam int LF_CODE       = 10;
   localparam int GLYPH_FIRST   = 32;
   localparam int GLYPH_SLOTS   = 128;
   localparam int GLYPH_STORED  = 100;
   localparam int PAGE_BYTES    = 128;
   localparam int ROW_LIMIT     = 15;
   localparam int RESET_CYCLES  = 8;
   localparam int RANDOM_CHARS  = 400;
   localparam int DRAIN_EVERY   = 130;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_LIMIT    = 1000;

   // How a scripted row gets its expected writes
   typedef enum logic [1:0] {
      CHECK_PREDICT,
      CHECK_SILENT,
      CHECK_BLANK
   } check_kind_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_EVERY4
   } stall_mode_type;

   typedef struct packed {
      tcr_pkg::req_type item;
      check_kind_type   kind;
      logic [9:0]       base;
   } script_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tcr_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tcr_pkg::rsp_type rsp_data;

   // Predicted cursor
   int cur_col = 0;
   int cur_row = 0;

   tcr_pkg::rsp_type pending_writes [$];

   int error_count    = 0;
   int chars_sent     = 0;
   int silent_chars   = 0;
   int writes_checked = 0;
   int quiet_cycles   = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 64;
   logic [1:0]     stall_phase = 2'd0;

   // Glyphs for codes 32 to 131, eight pixel columns each; low byte is the upper page
   logic [15:0] glyph_cols [0:799] = '{
      16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
      16'h0000,16'h0000,16'h0000,16'h33fc,16'h33fc,16'h0000,16'h0000,16'h0000,
      16'h0000,16'h00fc,16'h00fc,16'h0000,16'h0000,16'h00fc,16'h00fc,16'h0000,
      16'h0330,16'h0ffc,16'h0ffc,16'h0330,16'h0330,16'h0ffc,16'h0ffc,16'h0330,
      16'h0000,16'h0c78,16'h0cfc,16'h3ccf,16'h3ccf,16'h0fcc,16'h078c,16'h0000,
      16'h0000,16'h0c1c,16'h0f1c,16'h03c0,16'h00f0,16'h0e3c,16'h0e0c,16'h0000,
      16'h1f00,16'h3fce,16'h30ff,16'h33f3,16'h1f3f,16'h3f0e,16'h3300,16'h0000,
      16'h0000,16'h0000,16'h0000,16'h00fc,16'h00fc,16'h0000,16'h0000,16'h0000,
      16'h0000,16'h0000,16'h0000,16'h0ff0,16'h1ff8,16'h381c,16'h2004,16'h0000,
      16'h0000,16'h2004,16'h381c,16'h1ff8,16'h0ff0,16'h0000,16'h0000,16'h0000,
      16'h00c0,16'h0ccc,16'h0ffc,16'h03f0,16'h03f0,16'h0ffc,16'h0ccc,16'h00c0,
      16'h0000,16'h00c0,16'h00c0,16'h07f8,16'h07f8,16'h00c0,16'h00c0,16'h0000,
      16'h0000,16'h0000,16'hc000,16'h7c00,16'h3c00,16'h0000,16'h0000,16'h0000,
      16'h0000,16'h00c0,16'h00c0,16'h00c0,16'h00c0,16'h00c0,16'h00c0,16'h0000,
      16'h0000,16'h0000,16'h0000,16'h3c00,16'h3c00,16'h0000,16'h0000,16'h0000,
      16'h0000,16'h3800,16'h3e00,16'h0780,16'h01e0,16'h007c,16'h001c,16'h0000,
      16'h0000,16'h1ff8,16'h3ffc,16'h310c,16'h308c,16'h3ffc,16'h1ff8,16'h0000,
      16'h0000,16'h3000,16'h3030,16'h3ffc,16'h3ffc,16'h3000,16'h3000,16'h0000,
      16'h0000,16'h3038,16'h3c3c,16'h3f0c,16'h33cc,16'h30fc,16'h3038,16'h0000,
      16'h0000,16'h1c0c,16'h3c0c,16'h30cc,16'h33fc,16'h3f3c,16'h1c0c,16'h0000,
      16'h0000,16'h0f00,16'h0fc0,16'h0cf0,16'h3ffc,16'h3ffc,16'h0c00,16'h0000,
      16'h0000,16'h18fc,16'h38fc,16'h30cc,16'h30cc,16'h3fcc,16'h1f8c,16'h0000,
      16'h0000,16'h1ff0,16'h3ff8,16'h319c,16'h318c,16'h3f8c,16'h1f00,16'h0000,
      16'h0000,16'h000c,16'h3c0c,16'h3f0c,16'h03cc,16'h00fc,16'h003c,16'h0000,
      16'h0000,16'h1f38,16'h3ffc,16'h30cc,16'h30cc,16'h3ffc,16'h1f38,16'h0000,
      16'h0000,16'h0078,16'h30fc,16'h30cc,16'h38cc,16'h1ffc,16'h0ff8,16'h0000,
      16'h0000,16'h0000,16'h0000,16'h3cf0,16'h3cf0,16'h0000,16'h0000,16'h0000,
      16'h0000,16'h0000,16'hc000,16'h7cf0,16'h3cf0,16'h0000,16'h0000,16'h0000,
      16'h0080,16'h01c0,16'h03e0,16'h0770,16'h0e38,16'h0c18,16'h0808,16'h0000,
      16'h0000,16'h0330,16'h0330,16'h0330,16'h0330,16'h0330,16'h0330,16'h0000,
      16'h0808,16'h0c18,16'h0e38,16'h0770,16'h03e0,16'h01c0,16'h0080,16'h0000,
      16'h0000,16'h0038,16'h003c,16'h370c,16'h37cc,16'h00fc,16'h0038,16'h0000,
      16'h0ff0,16'h1ff8,16'h381c,16'h33cc,16'h324c,16'h3398,16'h19f0,16'h0000,
      16'h0000,16'h3ff0,16'h3ff8,16'h031c,16'h031c,16'h3ff8,16'h3ff0,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h30cc,16'h30cc,16'h3ffc,16'h1f78,16'h0000,
      16'h0000,16'h1ff8,16'h3ffc,16'h300c,16'h300c,16'h3c3c,16'h1c38,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h300c,16'h381c,16'h1ff8,16'h0ff0,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h30cc,16'h30cc,16'h30cc,16'h300c,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h00cc,16'h00cc,16'h00cc,16'h000c,16'h0000,
      16'h0000,16'h1ff8,16'h3ffc,16'h300c,16'h30cc,16'h3fcc,16'h1fcc,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h00c0,16'h00c0,16'h3ffc,16'h3ffc,16'h0000,
      16'h0000,16'h300c,16'h300c,16'h3ffc,16'h3ffc,16'h300c,16'h300c,16'h0000,
      16'h0000,16'h1c00,16'h3c00,16'h3000,16'h3000,16'h3ffc,16'h1ffc,16'h0000,
      16'h3ffc,16'h3ffc,16'h00c0,16'h03f0,16'h0f3c,16'h3c0c,16'h3000,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h3000,16'h3000,16'h3000,16'h3000,16'h0000,
      16'h3ffc,16'h3ffc,16'h0070,16'h01c0,16'h0070,16'h3ffc,16'h3ffc,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h01e0,16'h0780,16'h3ffc,16'h3ffc,16'h0000,
      16'h0000,16'h1ff8,16'h3ffc,16'h300c,16'h300c,16'h3ffc,16'h1ff8,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h030c,16'h030c,16'h03fc,16'h01f8,16'h0000,
      16'h0000,16'h1ff8,16'h3ffc,16'h300c,16'h180c,16'h37fc,16'h2ff8,16'h0000,
      16'h3ffc,16'h3ffc,16'h018c,16'h038c,16'h0ffc,16'h3cf8,16'h3000,16'h0000,
      16'h0000,16'h3078,16'h30fc,16'h31cc,16'h338c,16'h3f0c,16'h1e0c,16'h0000,
      16'h0000,16'h000c,16'h000c,16'h3ffc,16'h3ffc,16'h000c,16'h000c,16'h0000,
      16'h0000,16'h1ffc,16'h3ffc,16'h3000,16'h3000,16'h3ffc,16'h1ffc,16'h0000,
      16'h0000,16'h03fc,16'h0ffc,16'h3c00,16'h3c00,16'h0ffc,16'h03fc,16'h0000,
      16'h3ffc,16'h1ffc,16'h0e00,16'h0780,16'h0e00,16'h1ffc,16'h3ffc,16'h0000,
      16'h0000,16'h381c,16'h3e7c,16'h07e0,16'h07e0,16'h3e7c,16'h381c,16'h0000,
      16'h0000,16'h003c,16'h00fc,16'h3fc0,16'h3fc0,16'h00fc,16'h003c,16'h0000,
      16'h0000,16'h3c0c,16'h3f0c,16'h33cc,16'h30fc,16'h303c,16'h300c,16'h0000,
      16'h0000,16'h0000,16'h0000,16'h3ffc,16'h3ffc,16'h300c,16'h300c,16'h0000,
      16'h0000,16'h001c,16'h007c,16'h01e0,16'h0780,16'h3e00,16'h3800,16'h0000,
      16'h0000,16'h300c,16'h300c,16'h3ffc,16'h3ffc,16'h0000,16'h0000,16'h0000,
      16'h0180,16'h01e0,16'h0078,16'h001e,16'h0078,16'h01e0,16'h0180,16'h0000,
      16'h3000,16'h3000,16'h3000,16'h3000,16'h3000,16'h3000,16'h3000,16'h0000,
      16'h0000,16'h0007,16'h000e,16'h001c,16'h0038,16'h0070,16'h0000,16'h0000,
      16'h0000,16'h1e00,16'h3f60,16'h3360,16'h3360,16'h3fe0,16'h3fc0,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h3060,16'h3060,16'h3fe0,16'h1fc0,16'h0000,
      16'h0000,16'h1fc0,16'h3fe0,16'h3060,16'h3060,16'h3060,16'h3000,16'h0000,
      16'h0000,16'h1fc0,16'h3fe0,16'h3060,16'h3060,16'h3ffc,16'h3ffc,16'h0000,
      16'h0000,16'h1fc0,16'h3fe0,16'h3260,16'h3260,16'h33e0,16'h33c0,16'h0000,
      16'h0000,16'h00c0,16'h00c0,16'h3ff8,16'h3ffc,16'h00cc,16'h00cc,16'h0000,
      16'h0000,16'hcfc0,16'hdfe0,16'hd860,16'hd860,16'hffe0,16'h7fe0,16'h0000,
      16'h0000,16'h3ffc,16'h3ffc,16'h0060,16'h0060,16'h3fe0,16'h3fc0,16'h0000,
      16'h0000,16'h0000,16'h3060,16'h3fec,16'h3fec,16'h3000,16'h0000,16'h0000,
      16'h0000,16'hc000,16'hc000,16'hc000,16'hffec,16'h7fec,16'h0000,16'h0000,
      16'h3ffc,16'h3ffc,16'h0380,16'h07c0,16'h1ee0,16'h3860,16'h3000,16'h0000,
      16'h0000,16'h0000,16'h300c,16'h3ffc,16'h3ffc,16'h3000,16'h0000,16'h0000,
      16'h3fc0,16'h3fe0,16'h00e0,16'h07c0,16'h00e0,16'h3fe0,16'h3fc0,16'h0000,
      16'h0000,16'h3fc0,16'h3fe0,16'h0060,16'h0060,16'h3fe0,16'h3fc0,16'h0000,
      16'h0000,16'h1fc0,16'h3fe0,16'h3060,16'h3060,16'h3fe0,16'h1fc0,16'h0000,
      16'h0000,16'hffe0,16'hffe0,16'h3060,16'h3060,16'h3fe0,16'h1fc0,16'h0000,
      16'h0000,16'h1fc0,16'h3fe0,16'h3060,16'h3060,16'hffe0,16'hffe0,16'h0000,
      16'h0000,16'h3fe0,16'h3fe0,16'h0060,16'h0060,16'h00e0,16'h00c0,16'h0000,
      16'h0000,16'h31c0,16'h33e0,16'h3360,16'h3660,16'h3e60,16'h1c60,16'h0000,
      16'h0000,16'h0060,16'h0060,16'h1ff8,16'h3ff8,16'h3060,16'h3060,16'h0000,
      16'h0000,16'h1fe0,16'h3fe0,16'h3000,16'h3000,16'h3fe0,16'h3fe0,16'h0000,
      16'h0000,16'h03e0,16'h0fe0,16'h3c00,16'h3c00,16'h0fe0,16'h03e0,16'h0000,
      16'h3fe0,16'h1fe0,16'h0e00,16'h0780,16'h0e00,16'h1fe0,16'h3fe0,16'h0000,
      16'h0000,16'h3060,16'h3de0,16'h0f80,16'h0f80,16'h3de0,16'h3060,16'h0000,
      16'h0000,16'hcfe0,16'hdfe0,16'hd800,16'hd800,16'hffe0,16'h7fe0,16'h0000,
      16'h0000,16'h3060,16'h3c60,16'h3f60,16'h33e0,16'h30e0,16'h3060,16'h0000,
      16'h0180,16'h0180,16'h03c0,16'h3ffc,16'h7e7e,16'h4002,16'h4002,16'h0000,
      16'h0000,16'h0000,16'h0000,16'h7ffe,16'h7ffe,16'h0000,16'h0000,16'h0000,
      16'h4002,16'h4002,16'h7e7e,16'h3ffc,16'h03c0,16'h0180,16'h0180,16'h0000,
      16'h01c0,16'h0060,16'h00e0,16'h01c0,16'h0180,16'h0180,16'h00e0,16'h0000,
      16'h1800,16'h1e00,16'h1380,16'h10e0,16'h10e0,16'h1380,16'h1e00,16'h1800,
      16'h0000,16'h0030,16'h0078,16'h00f8,16'h01f0,16'h00f8,16'h0078,16'h0030,
      16'h0000,16'h0008,16'h0014,16'h0008,16'h00e0,16'h0110,16'h0110,16'h00a0,
      16'h0000,16'h1c00,16'h3f00,16'h3fcc,16'h3f00,16'h1c00,16'h0000,16'h0000,
      16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000
   };

   text_cell_renderer_8x16_unit #(
      .CELLS_PER_ROW(CELLS_PER_ROW),
      .PAGES        (PAGES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Cursor to column 0, two pages down; the row sticks at its limit
   function automatic void advance_line();
      cur_col = 0;
      cur_row = (cur_row + 2 > ROW_LIMIT) ? ROW_LIMIT : cur_row + 2;
   endfunction

   // Move the cursor for one character and queue the byte writes it should cause.
   // Scripted rows may impose silence or a blank cell at a typed-in address instead.
   function automatic void render_char(tcr_pkg::req_type item, check_kind_type kind,
                                       logic [9:0] typed_base);
      int               code;
      int               cell_base;
      int               i;
      bit               on_screen;
      logic [15:0]      pixels;
      tcr_pkg::rsp_type wr;
      code = int'(item.char_code);
      if (item.start_req) begin
         cur_col = int'(item.start_col);
         cur_row = int'(item.start_row);
      end
      if (code == LF_CODE) begin
         advance_line();
         silent_chars++;
         return;
      end
      on_screen = code >= GLYPH_FIRST && code < GLYPH_FIRST + GLYPH_SLOTS
                  && cur_col < CELLS_PER_ROW && cur_row + 1 < PAGES;
      cell_base = cur_row * PAGE_BYTES + cur_col * 8;
      if (kind == CHECK_SILENT) begin
         on_screen = 1'b0;
      end else if (kind == CHECK_BLANK) begin
         on_screen = 1'b1;
         cell_base = int'(typed_base);
      end
      if (on_screen) begin
         for (i = 0; i < 8; i++) begin
            if (kind == CHECK_PREDICT && code - GLYPH_FIRST < GLYPH_STORED) begin
               pixels = glyph_cols[(code - GLYPH_FIRST) * 8 + i];
            end else begin
               pixels = '0;
            end
            // upper page first, then the page below; only the final pair carries last
            wr.byte_addr = 10'(cell_base + i);
            wr.byte_data = pixels[7:0];
            wr.last      = 1'b0;
            pending_writes.push_back(wr);
            wr.byte_addr = 10'(cell_base + i + PAGE_BYTES);
            wr.byte_data = pixels[15:8];
            wr.last      = (i == 7);
            pending_writes.push_back(wr);
         end
      end else begin
         silent_chars++;
      end
      cur_col++;
      if (cur_col >= CELLS_PER_ROW) begin
         advance_line();
      end
   endfunction

   function automatic script_row_type mk(bit start, int col, int row, int code,
                                         check_kind_type kind, int base);
      script_row_type r;
      r.item.start_req = start;
      r.item.start_col = 4'(col);
      r.item.start_row = 3'(row);
      r.item.char_code = 8'(code);
      r.kind           = kind;
      r.base           = 10'(base);
      return r;
   endfunction

   // Mostly drawable text, with starts, newlines, blank glyphs and codes off the table
   function automatic tcr_pkg::req_type random_char();
      tcr_pkg::req_type it;
      int               pick;
      it.start_req = ($urandom_range(0, 99) < 18);
      it.start_col = 4'($urandom_range(0, 15));
      it.start_row = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         it.char_code = 8'($urandom_range(GLYPH_FIRST, GLYPH_FIRST + GLYPH_STORED - 1));
      end else if (pick < 76) begin
         it.char_code = 8'($urandom_range(GLYPH_FIRST + GLYPH_STORED,
                                          GLYPH_FIRST + GLYPH_SLOTS - 1));
      end else if (pick < 86) begin
         it.char_code = 8'(LF_CODE);
      end else if (pick < 93) begin
         it.char_code = 8'($urandom_range(0, GLYPH_FIRST - 1));
      end else begin
         it.char_code = 8'($urandom_range(GLYPH_FIRST + GLYPH_SLOTS, 255));
      end
      return it;
   endfunction

   // Offer one item and hold it until the block takes it, then predict its writes
   task automatic push_char(tcr_pkg::req_type item, check_kind_type kind, logic [9:0] base);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      render_char(item, kind, base);
      chars_sent++;
   endtask

   task automatic rest(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off the sender until every predicted write has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin : stimulus
      script_row_type script [$];
      int             burst;
      int             gap;
      int             k;
      int             random_sent;
      int             next_drain;

      // Cursor walk from reset: blank cell at the origin, glyphs, newline, codes just
      // off each end of the table, blank tail glyphs, the bottom-right cell and wrap,
      // rows off the screen, row saturation, and a start that only carries a newline.
      script.push_back(mk(0,  0, 0,  32, CHECK_BLANK,     0));
      script.push_back(mk(0,  0, 0,  33, CHECK_PREDICT,   0));
      script.push_back(mk(0,  0, 0,  10, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0,   0, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0,  31, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0, 159, CHECK_BLANK,   272));
      script.push_back(mk(0,  0, 0, 160, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0, 255, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0, 131, CHECK_PREDICT,   0));
      script.push_back(mk(0,  0, 0, 130, CHECK_PREDICT,   0));
      script.push_back(mk(1, 15, 6,  65, CHECK_PREDICT,   0));
      script.push_back(mk(0,  0, 0,  66, CHECK_SILENT,    0));
      script.push_back(mk(1,  0, 7,  67, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0,  10, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0,  10, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0,  10, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0,  10, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0,  10, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0,  90, CHECK_SILENT,    0));
      script.push_back(mk(1,  0, 0, 132, CHECK_BLANK,     0));
      script.push_back(mk(1, 15, 0, 127, CHECK_PREDICT,   0));
      script.push_back(mk(1,  8, 3,  10, CHECK_SILENT,    0));
      script.push_back(mk(0, 15, 7, 126, CHECK_PREDICT,   0));
      script.push_back(mk(1,  7, 5, 255, CHECK_SILENT,    0));
      script.push_back(mk(0,  0, 0, 128, CHECK_PREDICT,   0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[r]) begin
         push_char(script[r].item, script[r].kind, script[r].base);
      end
      wait_drained();

      // Random text in bursts; run back to back for a stretch, drain now and then
      random_sent = 0;
      next_drain  = DRAIN_EVERY;
      while (random_sent < RANDOM_CHARS) begin
         burst = $urandom_range(1, 12);
         for (k = 0; k < burst && random_sent < RANDOM_CHARS; k++) begin
            push_char(random_char(), CHECK_PREDICT, '0);
            random_sent++;
         end
         if (random_sent >= 200 && random_sent < 270) begin
            gap = 0;
         end else if ($urandom_range(0, 9) == 0) begin
            gap = $urandom_range(8, 24);
         end else begin
            gap = $urandom_range(0, 5);
         end
         if (random_sent >= next_drain) begin
            wait_drained();
            next_drain += DRAIN_EVERY;
         end else if (gap > 0) begin
            rest(gap);
         end
      end

      // Drop valid, let the last writes out, then give stray writes time to show
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d characters (%0d scripted, %0d random), %0d of them drew nothing;",
               chars_sent, script.size(), random_sent, silent_chars);
      $display("checked %0d byte writes under free, light, heavy and periodic output stalls.",
               writes_checked);
      if (error_count == 0) begin
         $display("[text_cell_renderer_8x16_unit] OK");
      end else begin
         $display("[text_cell_renderer_8x16_unit] ERROR");
      end
      $finish;
   end

   // Output stall: switch between stall patterns every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 160);
         end else begin
            mode_left <= mode_left - 1;
         end
         stall_phase <= stall_phase + 2'd1;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 20);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
            default:     rsp_stall <= (stall_phase == 2'd3);
         endcase
      end
   end

   // Compare every accepted write with the oldest predicted one
   always @(posedge clock) begin : check_writes
      tcr_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected write addr %0d data %02h last %0b", $time,
                     rsp_data.byte_addr, rsp_data.byte_data, rsp_data.last);
            error_count++;
         end else begin
            want = pending_writes.pop_front();
            writes_checked++;
            if (rsp_data.byte_addr !== want.byte_addr) begin
               $display("%0t: byte_addr expected %0d got %0d", $time,
                        want.byte_addr, rsp_data.byte_addr);
               error_count++;
            end
            if (rsp_data.byte_data !== want.byte_data) begin
               $display("%0t: byte_data at %0d expected %02h got %02h", $time,
                        want.byte_addr, want.byte_data, rsp_data.byte_data);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last at %0d expected %0b got %0b", $time,
                        want.byte_addr, want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // End the run if no item moves on either channel for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0)
                || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: nothing moved for %0d cycles, %0d writes still expected", $time,
                  quiet_cycles, pending_writes.size());
         $display("[text_cell_renderer_8x16_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
